FILE: hw/rtl/ppr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared widths, register indexes and the configuration record of the
// position PID regulator.
// ----------------------------------------------------------------------------
package ppr_pkg;

	// field widths
	localparam int POS_W      = 12;
	localparam int ERR_W      = 13;
	localparam int MAG_W      = 12;
	localparam int DERR_W     = 14;
	localparam int INTEG_W    = 16;
	localparam int ISUM_W     = 17;
	localparam int DRIVE_W    = 9;
	localparam int GAIN_W     = 8;
	localparam int IMAX_W     = 15;
	localparam int ANGLE_W    = 12;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	// term scaling as right shifts: /16, /32, /4
	localparam int P_SHIFT = 4;
	localparam int I_SHIFT = 5;
	localparam int D_SHIFT = 2;

	// product and sum widths
	localparam int P_PROD_W = 21;
	localparam int I_PROD_W = 24;
	localparam int D_PROD_W = 22;
	localparam int PWR_W    = 22;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_MAX   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_MIN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_ANGLE = 3'd7;

	typedef struct packed {
		logic        [GAIN_W-1:0]  deadband;
		logic        [GAIN_W-1:0]  gain_p;
		logic        [GAIN_W-1:0]  gain_i;
		logic        [GAIN_W-1:0]  gain_d;
		logic        [GAIN_W-1:0]  power_limit;
		logic        [IMAX_W-1:0]  integral_max;
		logic signed [INTEG_W-1:0] integral_min;
		logic        [ANGLE_W-1:0] integral_reset_angle;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		deadband:             8'd0,
		gain_p:               8'd16,
		gain_i:               8'd0,
		gain_d:               8'd0,
		power_limit:          8'd255,
		integral_max:         15'd1000,
		integral_min:         -16'sd1000,
		integral_reset_angle: 12'd100
	};

endpackage
`default_nettype wire

FILE: hw/rtl/ppr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppr channel interfaces
// Valid/ready channels carrying regulator requests and results.
// ----------------------------------------------------------------------------
interface ppr_cmd_if;
	logic                              valid;
	logic                              ready;
	logic signed [ppr_pkg::POS_W-1:0]  target_position;
	logic signed [ppr_pkg::POS_W-1:0]  actual_position;
	logic                              clear_state;

	modport source (output valid, target_position, actual_position, clear_state,
		input ready);
	modport sink (input valid, target_position, actual_position, clear_state,
		output ready);
endinterface

interface ppr_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [ppr_pkg::DRIVE_W-1:0] drive;
	logic signed [ppr_pkg::ERR_W-1:0]   position_error;

	modport source (output valid, drive, position_error, input ready);
	modport sink (input valid, drive, position_error, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/position_pid_regulator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// position_pid_regulator_unit
// Position PID regulator with deadband, integral clamp and output limit.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  : valid/ready request channel with target and actual position and a
//          clear_state flag that zeroes the previous error and the integral
//          before the request is processed.
//   rsp  : valid/ready result channel, one drive command and the error after
//          the deadband for every request.
//   cfg_*: plain register write port, one register per cycle, no read-back;
//          write only while no request is in flight.
// A request moves through three registers on its way to rsp.valid: the input
// register loads at acceptance, then the error/state stage register (previous
// error and integral update there), then the result register. One request per
// cycle is sustained while rsp.ready stays high; the state feedback closes
// within the error stage so consecutive requests need no spacing.
// Reset clears the state, the pipeline valids and loads the register defaults.
// When rsp.ready is low the result register holds and the stages behind it
// keep filling; cmd.ready falls once all three stages hold a request.
// ----------------------------------------------------------------------------
module position_pid_regulator_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [ppr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ppr_pkg::CFG_DATA_W-1:0]     cfg_data,
	ppr_cmd_if.sink                                 cmd,
	ppr_rsp_if.source                               rsp
);

	localparam int EW = ppr_pkg::ERR_W;
	localparam int MW = ppr_pkg::MAG_W;
	localparam int SW = ppr_pkg::ISUM_W;

	ppr_pkg::cfg_t cfg_q;

	// pipeline control
	logic s1_v_q, s2_v_q, rsp_v_q;
	logic out_load, s2_free, s1_free, adv_s1;

	// request stage
	logic signed [ppr_pkg::POS_W-1:0] tgt_s1, act_s1;
	logic                             clr_s1;

	// state
	logic signed [EW-1:0]               prev_err_q;
	logic signed [ppr_pkg::INTEG_W-1:0] integ_q;

	// error stage
	logic signed [EW-1:0]               raw_err;
	logic signed [EW-1:0]               raw_abs;
	logic        [MW-1:0]               raw_mag;
	logic        [MW-1:0]               db_mag;
	logic                               in_band;
	logic        [MW-1:0]               err_mag;
	logic signed [EW-1:0]               err;
	logic signed [EW-1:0]               prev_err;
	logic signed [ppr_pkg::INTEG_W-1:0] integ;
	logic signed [ppr_pkg::DERR_W-1:0]  derr;
	logic signed [SW-1:0]               isum_wide;
	logic signed [SW-1:0]               isum_hi;
	logic signed [SW-1:0]               isum_lo;
	logic signed [SW-1:0]               imax_ext;
	logic signed [SW-1:0]               imin_ext;
	logic signed [ppr_pkg::INTEG_W-1:0] isum;

	logic signed [EW-1:0]               err_s2;
	logic signed [ppr_pkg::DERR_W-1:0]  derr_s2;
	logic signed [ppr_pkg::INTEG_W-1:0] isum_s2;

	// result stage
	logic signed [ppr_pkg::DRIVE_W-1:0] drive_c;
	logic signed [ppr_pkg::DRIVE_W-1:0] drive_q;
	logic signed [EW-1:0]               perr_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ppr_pkg::CFG_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ppr_pkg::REG_DEADBAND:    cfg_q.deadband     <= cfg_data[ppr_pkg::GAIN_W-1:0];
				ppr_pkg::REG_GAIN_P:      cfg_q.gain_p       <= cfg_data[ppr_pkg::GAIN_W-1:0];
				ppr_pkg::REG_GAIN_I:      cfg_q.gain_i       <= cfg_data[ppr_pkg::GAIN_W-1:0];
				ppr_pkg::REG_GAIN_D:      cfg_q.gain_d       <= cfg_data[ppr_pkg::GAIN_W-1:0];
				ppr_pkg::REG_POWER_LIMIT: cfg_q.power_limit  <= cfg_data[ppr_pkg::GAIN_W-1:0];
				ppr_pkg::REG_INTEG_MAX:   cfg_q.integral_max <= cfg_data[ppr_pkg::IMAX_W-1:0];
				ppr_pkg::REG_INTEG_MIN:   cfg_q.integral_min <=
					$signed(cfg_data[ppr_pkg::INTEG_W-1:0]);
				ppr_pkg::REG_RESET_ANGLE: cfg_q.integral_reset_angle <=
					cfg_data[ppr_pkg::ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// stage advance, each stage loads when the one ahead frees up
	assign out_load  = !rsp_v_q || rsp.ready;
	assign s2_free   = !s2_v_q || out_load;
	assign s1_free   = !s1_v_q || s2_free;
	assign adv_s1    = s1_v_q && s2_free;
	assign cmd.ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			rsp_v_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_v_q <= cmd.valid;
			end
			if (s2_free) begin
				s2_v_q <= s1_v_q;
			end
			if (out_load) begin
				rsp_v_q <= s2_v_q;
			end
		end
	end

	// request register
	always_ff @(posedge clk) begin
		if (s1_free && cmd.valid) begin
			tgt_s1 <= cmd.target_position;
			act_s1 <= cmd.actual_position;
			clr_s1 <= cmd.clear_state;
		end
	end

	// raw error and deadband
	assign raw_err = $signed({tgt_s1[ppr_pkg::POS_W-1], tgt_s1})
		- $signed({act_s1[ppr_pkg::POS_W-1], act_s1});
	assign raw_abs = raw_err[EW-1] ? -raw_err : raw_err;
	assign raw_mag = raw_abs[MW-1:0];
	assign in_band = raw_mag <= MW'(cfg_q.deadband);
	assign db_mag  = raw_mag - MW'(cfg_q.deadband);
	assign err_mag = in_band ? '0 : db_mag;
	assign err     = raw_err[EW-1] ? -$signed({1'b0, err_mag}) : $signed({1'b0, err_mag});

	// state as seen by this request
	assign prev_err = clr_s1 ? '0 : prev_err_q;
	assign integ    = clr_s1 ? '0 : integ_q;

	assign derr = $signed({err[EW-1], err}) - $signed({prev_err[EW-1], prev_err});

	// integral: wide sum, upper clamp, lower clamp, then clear on large error
	assign isum_wide = $signed({integ[ppr_pkg::INTEG_W-1], integ})
		+ $signed({{(SW-EW){err[EW-1]}}, err});
	assign imax_ext  = $signed({{(SW-ppr_pkg::IMAX_W){1'b0}}, cfg_q.integral_max});
	assign imin_ext  = $signed({cfg_q.integral_min[ppr_pkg::INTEG_W-1], cfg_q.integral_min});
	assign isum_hi   = (isum_wide > imax_ext) ? imax_ext : isum_wide;
	assign isum_lo   = (isum_hi < imin_ext) ? imin_ext : isum_hi;
	assign isum      = (err_mag > MW'(cfg_q.integral_reset_angle))
		? '0 : isum_lo[ppr_pkg::INTEG_W-1:0];

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			integ_q    <= '0;
		end else if (adv_s1) begin
			prev_err_q <= err;
			integ_q    <= isum;
		end
	end

	// error stage register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			err_s2  <= err;
			derr_s2 <= derr;
			isum_s2 <= isum;
		end
	end

	// controller law
	ppr_drive_calc u_drive_calc (
		.cfg   (cfg_q),
		.err   (err_s2),
		.derr  (derr_s2),
		.integ (isum_s2),
		.drive (drive_c)
	);

	// result register
	always_ff @(posedge clk) begin
		if (out_load && s2_v_q) begin
			drive_q <= drive_c;
			perr_q  <= err_s2;
		end
	end

	assign rsp.valid          = rsp_v_q;
	assign rsp.drive          = drive_q;
	assign rsp.position_error = perr_q;

	// state only moves when a request leaves the error stage
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(prev_err_q) && $stable(integ_q))
		else $error("regulator state changed without a request");

	// previous error tracks the error handed to the law
	a_prev_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> prev_err_q == err_s2 && integ_q == isum_s2)
		else $error("state and error stage disagree");

	// a large error clears the integral
	a_integ_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (err_mag > MW'(cfg_q.integral_reset_angle)) |=> integ_q == '0)
		else $error("integral not cleared on large error");

endmodule
`default_nettype wire

FILE: hw/rtl/ppr_drive_calc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppr_drive_calc
// Weighted sum of the P, I and D terms with truncation toward zero and a
// symmetric clamp to the power limit.
// ----------------------------------------------------------------------------
module ppr_drive_calc (
	input  wire ppr_pkg::cfg_t                        cfg,
	input  wire logic signed [ppr_pkg::ERR_W-1:0]     err,
	input  wire logic signed [ppr_pkg::DERR_W-1:0]    derr,
	input  wire logic signed [ppr_pkg::INTEG_W-1:0]   integ,
	output logic signed [ppr_pkg::DRIVE_W-1:0]        drive
);

	localparam int P_Q_W = ppr_pkg::P_PROD_W - ppr_pkg::P_SHIFT;
	localparam int I_Q_W = ppr_pkg::I_PROD_W - ppr_pkg::I_SHIFT;
	localparam int D_Q_W = ppr_pkg::D_PROD_W - ppr_pkg::D_SHIFT;
	localparam int PW    = ppr_pkg::PWR_W;

	logic signed [ppr_pkg::P_PROD_W-1:0] p_prod, p_adj;
	logic signed [ppr_pkg::I_PROD_W-1:0] i_prod, i_adj;
	logic signed [ppr_pkg::D_PROD_W-1:0] d_prod, d_adj;
	logic signed [P_Q_W-1:0]             p_term;
	logic signed [I_Q_W-1:0]             i_term;
	logic signed [D_Q_W-1:0]             d_term;
	logic signed [PW-1:0]                pwr;
	logic signed [PW-1:0]                lim;
	logic signed [PW-1:0]                lim_neg;

	// gain products, gains are unsigned
	assign p_prod = $signed({{(ppr_pkg::P_PROD_W-ppr_pkg::ERR_W){err[ppr_pkg::ERR_W-1]}}, err})
		* $signed({{(ppr_pkg::P_PROD_W-ppr_pkg::GAIN_W){1'b0}}, cfg.gain_p});
	assign i_prod = $signed({{(ppr_pkg::I_PROD_W-ppr_pkg::INTEG_W){integ[ppr_pkg::INTEG_W-1]}},
		integ}) * $signed({{(ppr_pkg::I_PROD_W-ppr_pkg::GAIN_W){1'b0}}, cfg.gain_i});
	assign d_prod = $signed({{(ppr_pkg::D_PROD_W-ppr_pkg::DERR_W){derr[ppr_pkg::DERR_W-1]}},
		derr}) * $signed({{(ppr_pkg::D_PROD_W-ppr_pkg::GAIN_W){1'b0}}, cfg.gain_d});

	// bias negative products so the shift rounds toward zero
	assign p_adj = p_prod + (p_prod[ppr_pkg::P_PROD_W-1]
		? ppr_pkg::P_PROD_W'((1 << ppr_pkg::P_SHIFT) - 1) : '0);
	assign i_adj = i_prod + (i_prod[ppr_pkg::I_PROD_W-1]
		? ppr_pkg::I_PROD_W'((1 << ppr_pkg::I_SHIFT) - 1) : '0);
	assign d_adj = d_prod + (d_prod[ppr_pkg::D_PROD_W-1]
		? ppr_pkg::D_PROD_W'((1 << ppr_pkg::D_SHIFT) - 1) : '0);

	assign p_term = p_adj[ppr_pkg::P_PROD_W-1:ppr_pkg::P_SHIFT];
	assign i_term = i_adj[ppr_pkg::I_PROD_W-1:ppr_pkg::I_SHIFT];
	assign d_term = d_adj[ppr_pkg::D_PROD_W-1:ppr_pkg::D_SHIFT];

	// three-way sum
	assign pwr = $signed({{(PW-P_Q_W){p_term[P_Q_W-1]}}, p_term})
		+ $signed({{(PW-I_Q_W){i_term[I_Q_W-1]}}, i_term})
		+ $signed({{(PW-D_Q_W){d_term[D_Q_W-1]}}, d_term});

	assign lim     = $signed({{(PW-ppr_pkg::GAIN_W){1'b0}}, cfg.power_limit});
	assign lim_neg = -lim;

	// symmetric clamp
	always_comb begin
		priority if (pwr > lim) begin
			drive = lim[ppr_pkg::DRIVE_W-1:0];
		end else if (pwr < lim_neg) begin
			drive = lim_neg[ppr_pkg::DRIVE_W-1:0];
		end else begin
			drive = pwr[ppr_pkg::DRIVE_W-1:0];
		end
	end

endmodule
`default_nettype wire

FILE: tb/ppr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppr_checker
// Watches the register port and both channels of the position PID regulator.
// It keeps its own copy of the registers, the previous error and the integral,
// and works out the drive and error that each accepted request must produce.
// Each accepted result is compared with the oldest pending one.
// ----------------------------------------------------------------------------
module ppr_checker (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_write,
	input  wire logic [ppr_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [ppr_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  wire logic                                   cmd_valid,
	input  wire logic                                   cmd_ready,
	input  wire logic signed [ppr_pkg::POS_W-1:0]       target_position,
	input  wire logic signed [ppr_pkg::POS_W-1:0]       actual_position,
	input  wire logic                                   clear_state,
	input  wire logic                                   rsp_valid,
	input  wire logic                                   rsp_ready,
	input  wire logic signed [ppr_pkg::DRIVE_W-1:0]     drive,
	input  wire logic signed [ppr_pkg::ERR_W-1:0]       position_error,
	output int                                          mismatches,
	output int                                          outstanding
);
	import ppr_pkg::*;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic signed [ERR_W-1:0]   position_error;
	} drive_cmd_t;

	drive_cmd_t pending_drives[$];
	cfg_t       regs;
	int         last_error;
	int         integral;

	// one line per mismatch
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// register write, unused data bits dropped
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_DEADBAND:    regs.deadband = data[GAIN_W-1:0];
			REG_GAIN_P:      regs.gain_p = data[GAIN_W-1:0];
			REG_GAIN_I:      regs.gain_i = data[GAIN_W-1:0];
			REG_GAIN_D:      regs.gain_d = data[GAIN_W-1:0];
			REG_POWER_LIMIT: regs.power_limit = data[GAIN_W-1:0];
			REG_INTEG_MAX:   regs.integral_max = data[IMAX_W-1:0];
			REG_INTEG_MIN:   regs.integral_min = data[INTEG_W-1:0];
			REG_RESET_ANGLE: regs.integral_reset_angle = data[ANGLE_W-1:0];
			default: ;
		endcase
	endtask

	// one regulator update: deadband, pid terms, integral clamp and clear
	function automatic drive_cmd_t regulate(input logic signed [POS_W-1:0] tgt,
		input logic signed [POS_W-1:0] act, input logic clr);
		int         err;
		int         err_mag;
		int         derr;
		int         isum;
		int         power;
		int         limit;
		int         band;
		drive_cmd_t res;
		if (clr) begin
			last_error = 0;
			integral = 0;
		end
		band = int'(regs.deadband);
		err = int'(tgt) - int'(act);
		err_mag = (err < 0) ? -err : err;
		if (err_mag <= band)
			err = 0;
		else if (err > 0)
			err = err - band;
		else
			err = err + band;
		err_mag = (err < 0) ? -err : err;

		derr = err - last_error;
		last_error = err;

		// upper clamp first, then lower, so an inverted pair lands on the minimum
		isum = integral + err;
		if (isum > int'(regs.integral_max))
			isum = int'(regs.integral_max);
		if (isum < int'($signed(regs.integral_min)))
			isum = int'($signed(regs.integral_min));
		if (err_mag > int'(regs.integral_reset_angle))
			isum = 0;
		integral = isum;

		// each term truncates toward zero
		power = (err * int'(regs.gain_p)) / (1 << P_SHIFT)
			+ (isum * int'(regs.gain_i)) / (1 << I_SHIFT)
			+ (derr * int'(regs.gain_d)) / (1 << D_SHIFT);
		limit = int'(regs.power_limit);
		if (power > limit)
			power = limit;
		if (power < -limit)
			power = -limit;

		res.drive = power[DRIVE_W-1:0];
		res.position_error = err[ERR_W-1:0];
		return res;
	endfunction

	// compare one accepted result with the oldest prediction
	task automatic check_result();
		drive_cmd_t want;
		if (pending_drives.size() == 0) begin
			report_mismatch("result with no request pending", int'(drive), 0);
		end else begin
			want = pending_drives.pop_front();
			if (drive !== want.drive)
				report_mismatch("drive", int'(drive), int'(want.drive));
			if (position_error !== want.position_error)
				report_mismatch("position_error", int'(position_error),
					int'(want.position_error));
		end
	endtask

	// results leave before new requests enter the prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = CFG_RESET;
			last_error = 0;
			integral = 0;
			pending_drives.delete();
		end else begin
			if (cfg_write)
				write_register(cfg_index, cfg_data);
			if (rsp_valid && rsp_ready)
				check_result();
			if (cmd_valid && cmd_ready)
				pending_drives.push_back(regulate(target_position, actual_position,
					clear_state));
		end
		outstanding = pending_drives.size();
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the position PID regulator. A short directed set
// covers the position extremes, deadband edges, clearing and the output and
// integral clamps; then servo-like tracking runs under random register
// settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
	import ppr_pkg::*;

	localparam int LONG_HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT   = 3000;
	localparam int RANDOM_PHASES    = 8;
	localparam int PHASE_REQUESTS   = 172;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatch_count;
	int                    pending_count;
	int                    idle_cycles;
	bit                    no_idle;
	bit                    hold_off_req;

	ppr_cmd_if cmd_ch ();
	ppr_rsp_if rsp_ch ();

	position_pid_regulator_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	ppr_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd_valid       (cmd_ch.valid),
		.cmd_ready       (cmd_ch.ready),
		.target_position (cmd_ch.target_position),
		.actual_position (cmd_ch.actual_position),
		.clear_state     (cmd_ch.clear_state),
		.rsp_valid       (rsp_ch.valid),
		.rsp_ready       (rsp_ch.ready),
		.drive           (rsp_ch.drive),
		.position_error  (rsp_ch.position_error),
		.mismatches      (mismatch_count),
		.outstanding     (pending_count)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// gap lengths: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = int'($urandom_range(0, 99));
		if (no_idle || r < 55)
			return 0;
		if (r < 85)
			return int'($urandom_range(1, 3));
		if (r < 97)
			return int'($urandom_range(4, 12));
		return int'($urandom_range(20, 60));
	endfunction

	function automatic int clamp_pos(input int v);
		if (v > 2047)
			return 2047;
		if (v < -2048)
			return -2048;
		return v;
	endfunction

	// register settings, mostly tuned-looking, sometimes anything
	function automatic cfg_t random_settings();
		cfg_t s;
		s.deadband = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
		s.gain_p = 8'($urandom);
		s.gain_i = 8'($urandom);
		s.gain_d = 8'($urandom);
		s.power_limit = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom);
		s.integral_max = ($urandom_range(0, 1) == 1) ? 15'($urandom)
			: 15'($urandom_range(0, 2000));
		s.integral_min = ($urandom_range(0, 1) == 1) ? 16'(-int'($urandom_range(0, 32768)))
			: 16'(-int'($urandom_range(0, 2000)));
		s.integral_reset_angle = ($urandom_range(0, 1) == 1) ? 12'($urandom)
			: 12'($urandom_range(20, 400));
		return s;
	endfunction

	// one register write per falling edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
	endtask

	// all registers, with junk in the unused data bits
	task automatic load_settings(input cfg_t s);
		write_reg(REG_DEADBAND, {8'($urandom), s.deadband});
		write_reg(REG_GAIN_P, {8'($urandom), s.gain_p});
		write_reg(REG_GAIN_I, {8'($urandom), s.gain_i});
		write_reg(REG_GAIN_D, {8'($urandom), s.gain_d});
		write_reg(REG_POWER_LIMIT, {8'($urandom), s.power_limit});
		write_reg(REG_INTEG_MAX, {1'($urandom), s.integral_max});
		write_reg(REG_INTEG_MIN, s.integral_min);
		write_reg(REG_RESET_ANGLE, {4'($urandom), s.integral_reset_angle});
		cfg_write = 1'b0;
	endtask

	// offer one request after a random gap, return at the next falling edge
	task automatic send_request(input logic signed [POS_W-1:0] tgt,
		input logic signed [POS_W-1:0] act, input logic clr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid = 1'b1;
		cmd_ch.target_position = tgt;
		cmd_ch.actual_position = act;
		cmd_ch.clear_state = clr;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
	endtask

	// sender pause until every result is back, plus pipeline latency
	task automatic wait_for_results();
		cmd_ch.valid = 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// result side: random stalls, no-idle stretches and one long hold-off
	initial begin : receiver
		int stall_left;
		int run_left;
		stall_left = 0;
		run_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = LONG_HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready = 1'b1;
				if (run_left > 0) begin
					run_left--;
				end else begin
					run_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(30, 80))
						: int'($urandom_range(0, 6));
					stall_left = pick_gap();
				end
			end
		end
	end

	// watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// stimulus
	initial begin : stimulus
		cfg_t settings;
		int   track_tgt;
		int   track_act;
		int   step;
		int   r;
		logic signed [POS_W-1:0] tgt;
		logic signed [POS_W-1:0] act;
		logic clr;

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_DEADBAND;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.target_position = '0;
		cmd_ch.actual_position = '0;
		cmd_ch.clear_state = 1'b0;
		rsp_ch.ready = 1'b0;
		idle_cycles = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: position extremes, clearing, reset angle edge
		send_request(12'sd0, 12'sd0, 1'b0);
		send_request(12'sd2047, -12'sd2048, 1'b0);
		send_request(-12'sd2048, 12'sd2047, 1'b0);
		send_request(12'sd2047, 12'sd2047, 1'b1);
		send_request(-12'sd2048, -12'sd2048, 1'b0);
		send_request(12'sd100, 12'sd0, 1'b0);
		send_request(12'sd0, -12'sd101, 1'b0);
		send_request(12'sd5, 12'sd10, 1'b0);
		send_request(-12'sd1, 12'sd0, 1'b1);
		wait_for_results();

		// every register at its top
		settings.deadband = 8'd255;
		settings.gain_p = 8'd255;
		settings.gain_i = 8'd255;
		settings.gain_d = 8'd255;
		settings.power_limit = 8'd255;
		settings.integral_max = 15'd32767;
		settings.integral_min = -16'sd32768;
		settings.integral_reset_angle = 12'd4095;
		load_settings(settings);
		send_request(12'sd255, 12'sd0, 1'b0);
		send_request(12'sd256, 12'sd0, 1'b0);
		send_request(-12'sd256, 12'sd0, 1'b0);
		repeat (3) send_request(12'sd2047, -12'sd2048, 1'b0);
		send_request(-12'sd2048, 12'sd2047, 1'b0);
		send_request(12'sd2047, -12'sd2048, 1'b1);
		wait_for_results();

		// everything zero: zero power limit holds the drive at zero
		settings = '0;
		load_settings(settings);
		send_request(12'sd2047, -12'sd2048, 1'b0);
		send_request(-12'sd1, 12'sd0, 1'b0);
		wait_for_results();

		// integral minimum above its maximum, with deadband edges
		settings.deadband = 8'd3;
		settings.gain_p = 8'd16;
		settings.gain_i = 8'd255;
		settings.gain_d = 8'd7;
		settings.power_limit = 8'd255;
		settings.integral_max = 15'd20;
		settings.integral_min = 16'sd50;
		settings.integral_reset_angle = 12'd4095;
		load_settings(settings);
		send_request(12'sd10, 12'sd0, 1'b0);
		send_request(-12'sd10, 12'sd0, 1'b0);
		send_request(12'sd3, 12'sd0, 1'b0);
		send_request(12'sd4, 12'sd0, 1'b0);
		wait_for_results();

		// random settings, servo-like tracking with some noise
		track_tgt = 0;
		track_act = 0;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			load_settings(random_settings());
			no_idle = (p == 3);
			if (p == 1)
				hold_off_req = 1'b1;
			for (int i = 0; i < PHASE_REQUESTS; i++) begin
				r = int'($urandom_range(0, 99));
				if (r < 4) begin
					tgt = 12'($urandom);
					act = 12'($urandom);
					clr = 1'($urandom);
				end else begin
					if (r < 12) begin
						if ($urandom_range(0, 1) == 1)
							track_tgt = int'($signed(12'($urandom)));
						else
							track_tgt = clamp_pos(track_act + int'($urandom_range(0, 300)) - 150);
					end
					step = (track_tgt - track_act) / int'($urandom_range(2, 6))
						+ int'($urandom_range(0, 6)) - 3;
					track_act = clamp_pos(track_act + step);
					tgt = track_tgt[POS_W-1:0];
					act = track_act[POS_W-1:0];
					clr = ($urandom_range(0, 49) == 0);
				end
				send_request(tgt, act, clr);
			end
			wait_for_results();
		end
		no_idle = 1'b0;

		// drain and verdict
		wait_for_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
